// ----- hw/rtl/dvd_pkg.sv -----
package dvd_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic emit;
  } dvd_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic last;
    logic out_free;
  } dvd_status_t;

endpackage

// ----- hw/rtl/dvd_in_if.sv -----
interface dvd_in_if;
  logic                  valid;
  logic                  ready;
  dvd_pkg::value_t       value;
  logic                  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- hw/rtl/dvd_out_if.sv -----
interface dvd_out_if;
  logic valid;
  logic ready;
  logic has_duplicate;
  logic overflow;

  modport source (output valid, output has_duplicate, output overflow, input ready);
  modport sink   (input valid, input has_duplicate, input overflow, output ready);
endinterface

// ----- hw/rtl/dvd_ram.sv -----
module dvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/dvd_datapath.sv -----
module dvd_datapath #(
  parameter int MAX_ITEMS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dvd_pkg::dvd_cmd_t    cmd,
  output dvd_pkg::dvd_status_t status,
  input  dvd_pkg::value_t      in_value,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_has_duplicate,
  output logic                 out_overflow
);
  import dvd_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  value_t        val_r;
  logic          last_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] lim_r, lim_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          ovf_r, ovf_nxt;
  logic          dup_r, dup_nxt;
  logic          pend_r;
  logic          out_valid_r, out_valid_nxt;
  logic          out_dup_r;
  logic          out_ovf_r;

  logic          has_room;
  logic          wr_en;
  logic          rd_en;
  value_t        rd_data;

  assign has_room = cnt_r < CW'(MAX_ITEMS);
  assign wr_en    = cmd.load && has_room;
  assign rd_en    = cmd.scan && (idx_r < lim_r);

  dvd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_value),
    .re    (rd_en),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    cnt_nxt       = cnt_r;
    lim_nxt       = lim_r;
    idx_nxt       = idx_r;
    ovf_nxt       = ovf_r;
    dup_nxt       = dup_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (pend_r && (rd_data == val_r)) begin
      dup_nxt = 1'b1;
    end

    if (rd_en) begin
      idx_nxt = idx_r + CW'(1);
    end

    if (cmd.load) begin
      idx_nxt = '0;
      if (has_room) begin
        cnt_nxt = cnt_r + CW'(1);
        lim_nxt = dup_r ? '0 : cnt_r;
      end else begin
        ovf_nxt = 1'b1;
        lim_nxt = '0;
      end
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      cnt_nxt       = '0;
      ovf_nxt       = 1'b0;
      dup_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      lim_r       <= '0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
      dup_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      lim_r       <= lim_nxt;
      idx_r       <= idx_nxt;
      ovf_r       <= ovf_nxt;
      dup_r       <= dup_nxt;
      pend_r      <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r  <= in_value;
      last_r <= in_last;
    end
    if (cmd.emit) begin
      out_dup_r <= dup_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign status.scan_done = (idx_r >= lim_r) && !pend_r;
  assign status.last      = last_r;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_has_duplicate = out_dup_r;
  assign out_overflow      = out_ovf_r;

endmodule

// ----- hw/rtl/dvd_ctrl.sv -----
module dvd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dvd_pkg::dvd_status_t status,
  output dvd_pkg::dvd_cmd_t    cmd
);
  import dvd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = status.last ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/duplicate_value_detector_core.sv -----
// Duplicate value detector.
// in_if carries one list element per request (value, last); last marks the
// final element. out_if carries one result per list: has_duplicate is set
// if any two stored elements are equal, overflow if more than MAX_ITEMS
// elements arrived (the excess is dropped and not compared).
// Each accepted element is written to the store and compared against the
// n elements already held, one store read per cycle through the single
// read port; no comparison is made once a duplicate is known or the store
// is full. in_ready stays low until an element is done, so the block takes
// a new element only once it is through with the previous one. The result
// of a list is registered for out_if after its last element is done.
// The result sits in an output register; the block resets its count and
// carries on with the next list while the result waits. If a further
// result is ready before the previous one is taken, the block holds
// in_ready low until out_if.ready frees the register.
// Synchronous reset clears the count, flags and any pending result; the
// store itself is not cleared.
module duplicate_value_detector_core #(
  parameter int MAX_ITEMS = 256
) (
  input  logic clk,
  input  logic rst_n,
  dvd_in_if.sink    in_if,
  dvd_out_if.source out_if
);
  import dvd_pkg::*;

  dvd_cmd_t    cmd;
  dvd_status_t status;

  dvd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dvd_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_value          (in_if.value),
    .in_last           (in_if.last),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_has_duplicate (out_if.has_duplicate),
    .out_overflow      (out_if.overflow)
  );

endmodule

// ----- hw/rtl/dvd_checker.sv -----
module dvd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_has_duplicate,
  input logic out_overflow
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_has_duplicate)
      && $stable(out_overflow))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request accepted while previous one in progress");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_last |=> !$rose(out_valid))
    else $error("result without a last request");

endmodule

bind duplicate_value_detector_core dvd_checker u_dvd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .in_last           (in_if.last),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_has_duplicate (out_if.has_duplicate),
  .out_overflow      (out_if.overflow)
);

// ----- bench/tb_duplicate_value_detector_core.sv -----
`timescale 1ns / 1ps

module tb_duplicate_value_detector_core;
  import dvd_pkg::*;

  localparam int MAX_ITEMS = 256;
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASES = 4;
  localparam int PHASE_ITEMS = 45;
  localparam int GAP_PCT[PHASES] = '{0, 82, 0, 19};
  localparam int STALL_PCT[PHASES] = '{0, 0, 82, 19};
  localparam int SCRIPT_ROWS = 17;

  typedef struct packed {
    logic dup;
    logic ovf;
  } verdict_t;

  typedef struct packed {
    value_t value;
    logic   last;
    logic   quoted;
    logic   dup;
    logic   ovf;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  dvd_in_if  in_if ();
  dvd_out_if out_if ();

  duplicate_value_detector_core #(
    .MAX_ITEMS(MAX_ITEMS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // directed lists; quoted rows carry a hand-worked verdict
  script_row_t script [SCRIPT_ROWS] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b1, 1'b1, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'hAAAA_AAAB, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h5555_5555, 1'b1, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0007, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0007, 1'b1, 1'b1, 1'b1, 1'b0}
  };

  value_t   held_values [MAX_ITEMS];
  int       held_n;
  logic     spilled;
  verdict_t verdicts_due [$];
  verdict_t want;

  int send_gap_pct;
  int stall_pct;
  int errors;
  int quiet_cycles;
  int elements_sent;
  int lists_done;
  int repeats_found;
  int overflows_found;

  // reference behaviour: store while room remains, compare on the last element
  task automatic fold_element(input value_t v, input logic fin,
                              output logic emits, output verdict_t r);
    int i;
    int j;
    r = '0;
    emits = fin;
    if (held_n < MAX_ITEMS) begin
      held_values[held_n] = v;
      held_n++;
    end else begin
      spilled = 1'b1;
    end
    if (fin) begin
      for (i = 1; i < held_n; i++)
        for (j = 0; j < i; j++)
          if (held_values[i] == held_values[j]) r.dup = 1'b1;
      r.ovf = spilled;
      held_n = 0;
      spilled = 1'b0;
    end
  endtask

  task automatic push_element(input value_t v, input logic fin,
                              input logic quoted, input verdict_t quoted_v);
    verdict_t got;
    logic     emits;
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.last  <= fin;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    elements_sent++;
    fold_element(v, fin, emits, got);
    if (emits) begin
      if (quoted) got = quoted_v;
      verdicts_due.push_back(got);
      lists_done++;
      repeats_found += got.dup;
      overflows_found += got.ovf;
    end
  endtask

  task automatic send_list(input value_t vals [$]);
    int k;
    for (k = 0; k < vals.size(); k++)
      push_element(vals[k], k == vals.size() - 1, 1'b0, '0);
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return value_t'($urandom_range(7));
    endcase
  endfunction

  task automatic random_lists(input int budget);
    value_t vals [$];
    int     sent;
    int     len;
    int     mode;
    int     i;
    int     j;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      mode = $urandom_range(3);
      vals.delete();
      for (i = 0; i < len; i++) begin
        case (mode)
          0, 2: vals.push_back(value_t'($urandom()));
          1: vals.push_back(pick_value());
          default: vals.push_back($urandom_range(1) ? value_t'($urandom()) : pick_value());
        endcase
      end
      // plant one repeat in a mostly distinct list
      if (mode == 2 && len > 1) begin
        j = $urandom_range(len - 1, 1);
        i = $urandom_range(j - 1, 0);
        vals[j] = vals[i];
      end
      send_list(vals);
      sent += len;
    end
  endtask

  // distinct values (odd stride), optionally one copy of element lo at hi
  task automatic long_list(input int len, input int lo, input int hi);
    value_t vals [$];
    value_t base;
    int     i;
    base = value_t'($urandom());
    for (i = 0; i < len; i++) vals.push_back(base + value_t'(i) * 32'h9E37_79B9);
    if (lo >= 0) vals[hi] = vals[lo];
    send_list(vals);
  endtask

  // full store, then a dropped last element that repeats a stored one
  task automatic long_lists();
    long_list(MAX_ITEMS + 1, 10, MAX_ITEMS);
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: result with none pending: dup=%0b ovf=%0b",
                 $time, out_if.has_duplicate, out_if.overflow);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_if.has_duplicate !== want.dup) begin
          $display("%0t: has_duplicate expected %0b actual %0b",
                   $time, want.dup, out_if.has_duplicate);
          errors++;
        end
        if (out_if.overflow !== want.ovf) begin
          $display("%0t: overflow expected %0b actual %0b",
                   $time, want.ovf, out_if.overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, verdicts_due.size());
      $display("tb_duplicate_value_detector_core failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int r;
    int p;
    errors = 0;
    elements_sent = 0;
    lists_done = 0;
    repeats_found = 0;
    overflows_found = 0;
    held_n = 0;
    spilled = 1'b0;
    send_gap_pct = 0;
    stall_pct = 0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    in_if.last <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < SCRIPT_ROWS; r++)
      push_element(script[r].value, script[r].last, script[r].quoted,
                   verdict_t'({script[r].dup, script[r].ovf}));

    for (p = 0; p < PHASES; p++) begin
      send_gap_pct = GAP_PCT[p];
      stall_pct = STALL_PCT[p];
      random_lists(PHASE_ITEMS);
      if (p == 0) long_lists();
    end
    in_if.valid <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d elements in %0d lists under four idling mixes", elements_sent, lists_done);
    $display("%0d lists held a repeat, %0d ran past capacity", repeats_found, overflows_found);
    if (errors == 0) begin
      $display("tb_duplicate_value_detector_core passed");
    end else begin
      $display("tb_duplicate_value_detector_core failed");
    end
    $finish;
  end

endmodule
